/* hdl/stto_pkg.sv */
// Shared constants and register index codes for the sphere-triangle overlap test.
package stto_pkg;

  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int PIPE_STAGES = 9;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

endpackage

/* hdl/sphere_triangle_overlap_test.sv */
// Top level: pipelined separating-axis overlap test of a triangle against a sphere.
// Ten register stages lie between an accepted triangle and its result.
// Throughput: one triangle per cycle; the whole pipeline holds while a result waits.
// Pipeline depth is set by the two chained wide multiplies (each split into 32-bit partials).
// Reset (rst_n low, synchronous) empties the pipeline and clears center and radius to 0.
module sphere_triangle_overlap_test #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stto_pkg::ADDR_W-1:0]         paddr,
  input  logic [stto_pkg::DATA_W-1:0]         pwdata,
  output logic [stto_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_ax,
  input  logic signed [COORD_BITS-1:0]        in_ay,
  input  logic signed [COORD_BITS-1:0]        in_az,
  input  logic signed [COORD_BITS-1:0]        in_bx,
  input  logic signed [COORD_BITS-1:0]        in_by,
  input  logic signed [COORD_BITS-1:0]        in_bz,
  input  logic signed [COORD_BITS-1:0]        in_cx,
  input  logic signed [COORD_BITS-1:0]        in_cy,
  input  logic signed [COORD_BITS-1:0]        in_cz,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit
);

  import stto_pkg::*;

  localparam int N    = COORD_BITS;
  localparam int AW   = N + 1;
  localparam int EW   = N + 2;
  localparam int GW   = 2 * N + 4;
  localparam int LW   = 2 * N + 5;
  localparam int RW   = 2 * N + 1;
  localparam int PAW  = AW + LW;
  localparam int PW   = PAW + 2;
  localparam int VVW  = 2 * LW;
  localparam int VSW  = VVW + 2;
  localparam int EDW  = EW + LW;
  localparam int QW   = EDW + 2;
  localparam int QOW  = QW + 1;
  localparam int EEW  = 2 * LW;
  localparam int LHW  = 2 * QW + 2;
  localparam int DTW  = QW + QOW + 2;
  localparam int RHW  = RW + EEW;
  localparam int CPW  = ((2 * PW > RW + VSW) ? 2 * PW : RW + VSW) + 1;
  localparam int CEW  = ((LHW > RHW) ? LHW : RHW) + 1;

  // configuration
  logic signed [N-1:0]      ctr_r [3];
  logic [N-1:0]             rad_r;
  logic [2*N-1:0]           rr_r;
  logic signed [RW-1:0]     rr_s;
  logic signed [GW-1:0]     rr_g;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  // pipeline control
  logic                     pipe_en;
  logic [PIPE_STAGES-1:0]   vld_r;
  logic                     out_valid_r;
  logic                     out_hit_r;

  logic signed [N-1:0]      vin [3][3];
  logic signed [AW-1:0]     vtx1_r [3][3];
  logic signed [AW-1:0]     vtx2_r [3][3];
  logic signed [EW-1:0]     ed2_r [3][3];
  logic signed [GW-1:0]     g2_r [3][3];
  logic signed [AW-1:0]     vtx3_r [3][3];
  logic signed [EW-1:0]     ed3_r [3][3];
  logic signed [LW-1:0]     v3_r [3];
  logic signed [LW-1:0]     elen3_r [3];
  logic signed [LW-1:0]     dd3_r [3];
  logic                     vsep_nxt;
  logic [6:0]               vsep_r;

  logic signed [PAW-1:0]    pav [3];
  logic signed [VVW-1:0]    vv [3];
  logic signed [EEW-1:0]    ee [3];
  logic signed [PAW-1:0]    pe [3][3];
  logic signed [PAW-1:0]    re [3][3];
  logic signed [EDW-1:0]    edd [3][3];

  logic signed [PW-1:0]     dp6_r;
  logic signed [VSW-1:0]    vs6_r;
  logic signed [QW-1:0]     qv6_r [3][3];
  logic signed [QOW-1:0]    qo6_r [3][3];
  logic signed [EEW-1:0]    ee6_r [3];

  logic signed [2*PW-1:0]   dp2;
  logic signed [RW+VSW-1:0] rv;
  logic signed [2*QW-1:0]   qq [3][3];
  logic signed [QW+QOW-1:0] qr [3][3];
  logic signed [RHW-1:0]    rre [3];

  logic                     psep9_r;
  logic signed [LHW-1:0]    lhs9_r [3];
  logic signed [DTW-1:0]    dot9_r [3];
  logic signed [RHW-1:0]    rhs9_r [3];
  logic [2:0]               esep;
  logic                     hit_nxt;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      rad_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X: ctr_r[0] <= pwdata[N-1:0];
        REG_CENTER_Y: ctr_r[1] <= pwdata[N-1:0];
        REG_CENTER_Z: ctr_r[2] <= pwdata[N-1:0];
        REG_RADIUS:   rad_r    <= pwdata[N-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = DATA_W'($unsigned(ctr_r[0]));
      REG_CENTER_Y: prdata = DATA_W'($unsigned(ctr_r[1]));
      REG_CENTER_Z: prdata = DATA_W'($unsigned(ctr_r[2]));
      REG_RADIUS:   prdata = DATA_W'(rad_r);
      default:      prdata = '0;
    endcase
  end

  // radius squared, registered; it settles in the cycle after the radius register takes a write
  always_ff @(posedge clk) begin
    rr_r <= rad_r * rad_r;
  end

  assign rr_s = $signed({1'b0, rr_r});
  assign rr_g = GW'(rr_s);

  // ---------------- pipeline control ----------------
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r       <= {vld_r[PIPE_STAGES-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_STAGES-1];
    end
  end

  // ---------------- stage 1: vertices relative to center ----------------
  assign vin[0][0] = in_ax;
  assign vin[0][1] = in_ay;
  assign vin[0][2] = in_az;
  assign vin[1][0] = in_bx;
  assign vin[1][1] = in_by;
  assign vin[1][2] = in_bz;
  assign vin[2][0] = in_cx;
  assign vin[2][1] = in_cy;
  assign vin[2][2] = in_cz;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          vtx1_r[j][i] <= AW'(vin[j][i]) - AW'(ctr_r[i]);
        end
      end
    end
  end

  // ---------------- stage 2: edges and vertex dot products ----------------
  // edge k runs from vertex k to vertex k+1
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          vtx2_r[k][i] <= vtx1_r[k][i];
          ed2_r[k][i]  <= EW'(vtx1_r[(k + 1) % 3][i]) - EW'(vtx1_r[k][i]);
        end
        for (int m = 0; m < 3; m++) begin
          g2_r[k][m] <= GW'(vtx1_r[k][0]) * GW'(vtx1_r[m][0])
                      + GW'(vtx1_r[k][1]) * GW'(vtx1_r[m][1])
                      + GW'(vtx1_r[k][2]) * GW'(vtx1_r[m][2]);
        end
      end
    end
  end

  // ---------------- stage 3: normal, edge terms, vertex tests ----------------
  always_comb begin
    vsep_nxt = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (g2_r[j][j] > rr_g && g2_r[j][(j + 1) % 3] > g2_r[j][j]
          && g2_r[j][(j + 2) % 3] > g2_r[j][j]) begin
        vsep_nxt = 1'b1;
      end
    end
  end

  // normal = (c - a) x (b - a) reversed in sign; only its square and dp^2 matter
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      v3_r[0] <= LW'(ed2_r[2][1]) * LW'(ed2_r[0][2]) - LW'(ed2_r[2][2]) * LW'(ed2_r[0][1]);
      v3_r[1] <= LW'(ed2_r[2][2]) * LW'(ed2_r[0][0]) - LW'(ed2_r[2][0]) * LW'(ed2_r[0][2]);
      v3_r[2] <= LW'(ed2_r[2][0]) * LW'(ed2_r[0][1]) - LW'(ed2_r[2][1]) * LW'(ed2_r[0][0]);
      for (int k = 0; k < 3; k++) begin
        elen3_r[k] <= LW'(ed2_r[k][0]) * LW'(ed2_r[k][0])
                    + LW'(ed2_r[k][1]) * LW'(ed2_r[k][1])
                    + LW'(ed2_r[k][2]) * LW'(ed2_r[k][2]);
        dd3_r[k]   <= LW'(vtx2_r[k][0]) * LW'(ed2_r[k][0])
                    + LW'(vtx2_r[k][1]) * LW'(ed2_r[k][1])
                    + LW'(vtx2_r[k][2]) * LW'(ed2_r[k][2]);
        for (int i = 0; i < 3; i++) begin
          vtx3_r[k][i] <= vtx2_r[k][i];
          ed3_r[k][i]  <= ed2_r[k][i];
        end
      end
      vsep_r <= {vsep_r[5:0], vsep_nxt};
    end
  end

  // ---------------- stages 4-5: first wide products ----------------
  for (genvar i = 0; i < 3; i++) begin : g_plane1
    stto_mul #(.AW(AW), .BW(LW)) u_pav (
      .clk(clk), .en(pipe_en), .a(vtx3_r[0][i]), .b(v3_r[i]), .p(pav[i])
    );
    stto_mul #(.AW(LW), .BW(LW)) u_vv (
      .clk(clk), .en(pipe_en), .a(v3_r[i]), .b(v3_r[i]), .p(vv[i])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_edge1
    stto_mul #(.AW(LW), .BW(LW)) u_ee (
      .clk(clk), .en(pipe_en), .a(elen3_r[k]), .b(elen3_r[k]), .p(ee[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_axis
      stto_mul #(.AW(AW), .BW(LW)) u_pe (
        .clk(clk), .en(pipe_en), .a(vtx3_r[k][i]), .b(elen3_r[k]), .p(pe[k][i])
      );
      // opposite vertex of edge k is vertex k+2
      stto_mul #(.AW(AW), .BW(LW)) u_re (
        .clk(clk), .en(pipe_en), .a(vtx3_r[(k + 2) % 3][i]), .b(elen3_r[k]), .p(re[k][i])
      );
      stto_mul #(.AW(EW), .BW(LW)) u_edd (
        .clk(clk), .en(pipe_en), .a(ed3_r[k][i]), .b(dd3_r[k]), .p(edd[k][i])
      );
    end
  end

  // ---------------- stage 6: plane dot, closest-point vectors ----------------
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dp6_r <= PW'(pav[0]) + PW'(pav[1]) + PW'(pav[2]);
      vs6_r <= VSW'(vv[0]) + VSW'(vv[1]) + VSW'(vv[2]);
      for (int k = 0; k < 3; k++) begin
        ee6_r[k] <= ee[k];
        for (int i = 0; i < 3; i++) begin
          qv6_r[k][i] <= QW'(pe[k][i]) - QW'(edd[k][i]);
          qo6_r[k][i] <= QOW'(re[k][i]) - QOW'(pe[k][i]) + QOW'(edd[k][i]);
        end
      end
    end
  end

  // ---------------- stages 7-8: second wide products ----------------
  stto_mul #(.AW(PW), .BW(PW)) u_dp2 (
    .clk(clk), .en(pipe_en), .a(dp6_r), .b(dp6_r), .p(dp2)
  );
  stto_mul #(.AW(RW), .BW(VSW)) u_rv (
    .clk(clk), .en(pipe_en), .a(rr_s), .b(vs6_r), .p(rv)
  );

  for (genvar k = 0; k < 3; k++) begin : g_edge2
    stto_mul #(.AW(RW), .BW(EEW)) u_rre (
      .clk(clk), .en(pipe_en), .a(rr_s), .b(ee6_r[k]), .p(rre[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_axis
      stto_mul #(.AW(QW), .BW(QW)) u_qq (
        .clk(clk), .en(pipe_en), .a(qv6_r[k][i]), .b(qv6_r[k][i]), .p(qq[k][i])
      );
      stto_mul #(.AW(QW), .BW(QOW)) u_qr (
        .clk(clk), .en(pipe_en), .a(qv6_r[k][i]), .b(qo6_r[k][i]), .p(qr[k][i])
      );
    end
  end

  // ---------------- stage 9: plane compare, edge sums ----------------
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      psep9_r <= CPW'(dp2) > CPW'(rv);
      for (int k = 0; k < 3; k++) begin
        lhs9_r[k] <= LHW'(qq[k][0]) + LHW'(qq[k][1]) + LHW'(qq[k][2]);
        dot9_r[k] <= DTW'(qr[k][0]) + DTW'(qr[k][1]) + DTW'(qr[k][2]);
        rhs9_r[k] <= rre[k];
      end
    end
  end

  // ---------------- stage 10: result register ----------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      esep[k] = (CEW'(lhs9_r[k]) > CEW'(rhs9_r[k]))
                && !dot9_r[k][DTW-1] && (dot9_r[k] != '0);
    end
    hit_nxt = !(psep9_r || vsep_r[6] || (|esep));
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline valid bits moved during a stall");

  a_last_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && vld_r[PIPE_STAGES-1] |=> out_valid_r)
    else $error("request in last stage did not reach the output");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(vld_r[PIPE_STAGES-1]))
    else $error("result appeared without a request in the last stage");

endmodule

/* hdl/stto_mul.sv */
// Two-stage signed multiplier built from 32x32 partial products.
module stto_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LIMB = 31;
  localparam int NA   = (AW + LIMB - 1) / LIMB;
  localparam int NB   = (BW + LIMB - 1) / LIMB;
  localparam int AXW  = NA * LIMB;
  localparam int BXW  = NB * LIMB;
  localparam int PW   = AW + BW;

  logic signed [AXW-1:0]      a_ext;
  logic signed [BXW-1:0]      b_ext;
  logic signed [LIMB:0]       al [NA];
  logic signed [LIMB:0]       bl [NB];
  logic signed [2*LIMB+1:0]   pp_r [NA][NB];
  logic signed [PW-1:0]       sum_nxt;
  logic signed [PW-1:0]       p_r;

  // low limbs are unsigned, the top limb carries the sign
  always_comb begin
    a_ext = AXW'(a);
    b_ext = BXW'(b);
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        al[i] = {a_ext[AXW-1], a_ext[i*LIMB +: LIMB]};
      end else begin
        al[i] = {1'b0, a_ext[i*LIMB +: LIMB]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bl[j] = {b_ext[BXW-1], b_ext[j*LIMB +: LIMB]};
      end else begin
        bl[j] = {1'b0, b_ext[j*LIMB +: LIMB]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= al[i] * bl[j];
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (PW'(pp_r[i][j]) <<< ((i + j) * LIMB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum_nxt;
    end
  end

  assign p = p_r;

endmodule
